### rtl/core/aobf_pkg.sv
// shared constants, codes and types for the audio output byte fifo
package aobf_pkg;

    localparam int BUFFER_BYTES = 16384;
    localparam int PTR_W        = $clog2(BUFFER_BYTES);
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
    localparam int BYTE_W       = 8;
    localparam int FILL_W       = 15;
    localparam int THR_W        = 15;
    localparam int CMP_W        = (CNT_W > THR_W) ? CNT_W : THR_W;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 15;

    // busy threshold after reset: 5/8 of the buffer
    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(10240);

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_REFUSED  = 2'd2,
        ST_UNDERRUN = 2'd3
    } status_t;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_READ  = 1'b1
    } action_t;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKING  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(1);

    // result of one transaction, waiting for the memory read data
    typedef struct packed {
        logic              rd_ok;
        status_t           status;
        logic [FILL_W-1:0] fill;
        logic              busy;
    } pend_t;

    // one access to the byte store
    typedef struct packed {
        logic              en;
        logic              we;
        logic [PTR_W-1:0]  addr;
        logic [BYTE_W-1:0] wdata;
    } mem_req_t;

endpackage

### rtl/core/aobf_ram.sv
// generic single-port ram with registered read
module aobf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/aobf_ctrl.sv
// pointer, fill count and config registers; issues at most one byte store access per transaction
module aobf_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  logic                                action,
    input  logic [aobf_pkg::BYTE_W-1:0]         write_byte,
    input  logic                                cfg_we,
    input  logic [aobf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aobf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output aobf_pkg::mem_req_t                  mem_req,
    output aobf_pkg::pend_t                     res
);

    logic [aobf_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [aobf_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [aobf_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       blocking_reg;
    logic [aobf_pkg::THR_W-1:0] thr_reg;

    logic                       full, empty;
    logic                       do_write, do_read;
    logic [aobf_pkg::CMP_W-1:0] room;
    aobf_pkg::status_t          status;

    assign full  = (count_reg >= aobf_pkg::CNT_W'(aobf_pkg::BUFFER_BYTES));
    assign empty = (count_reg == '0);

    assign do_write = accept && (action == aobf_pkg::ACT_WRITE) && !full;
    assign do_read  = accept && (action == aobf_pkg::ACT_READ) && !empty;

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (do_write) begin
            wr_ptr_next = (wr_ptr_reg == aobf_pkg::PTR_W'(aobf_pkg::BUFFER_BYTES - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        if (do_read) begin
            rd_ptr_next = (rd_ptr_reg == aobf_pkg::PTR_W'(aobf_pkg::BUFFER_BYTES - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_comb begin
        status = aobf_pkg::ST_DONE;
        if (action == aobf_pkg::ACT_WRITE) begin
            if (full) begin
                status = blocking_reg ? aobf_pkg::ST_REFUSED : aobf_pkg::ST_DROPPED;
            end
        end else begin
            if (empty) begin
                status = aobf_pkg::ST_UNDERRUN;
            end
        end
    end

    assign room = aobf_pkg::CMP_W'(aobf_pkg::BUFFER_BYTES) - aobf_pkg::CMP_W'(count_next);

    assign res.rd_ok  = do_read;
    assign res.status = status;
    assign res.fill   = aobf_pkg::FILL_W'(count_next);
    assign res.busy   = (room < aobf_pkg::CMP_W'(thr_reg));

    assign mem_req.en    = do_write || do_read;
    assign mem_req.we    = do_write;
    assign mem_req.addr  = do_write ? wr_ptr_reg : rd_ptr_reg;
    assign mem_req.wdata = write_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            count_reg    <= '0;
            blocking_reg <= 1'b0;
            thr_reg      <= aobf_pkg::THRESHOLD_RESET;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (cfg_we && (cfg_index == aobf_pkg::CFG_BLOCKING)) begin
                blocking_reg <= cfg_wdata[0];
            end
            if (cfg_we && (cfg_index == aobf_pkg::CFG_THRESHOLD)) begin
                thr_reg <= aobf_pkg::THR_W'(cfg_wdata);
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= aobf_pkg::CNT_W'(aobf_pkg::BUFFER_BYTES))
        else $error("fill count above buffer size");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("empty buffer with unequal pointers");

    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && full && (action == aobf_pkg::ACT_WRITE)) |=>
        ($stable(count_reg) && $stable(wr_ptr_reg)))
        else $error("state changed on a write into a full buffer");

endmodule

### rtl/core/aobf_out.sv
// holds the result while the read data comes back, then the output register
module aobf_out (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  aobf_pkg::pend_t             res,
    input  logic [aobf_pkg::BYTE_W-1:0] mem_rdata,
    output logic                        s_ready,
    input  logic                        m_ready,
    output logic                        m_valid,
    output logic [aobf_pkg::BYTE_W-1:0] m_read_byte,
    output logic [1:0]                  m_status,
    output logic [aobf_pkg::FILL_W-1:0] m_fill_level,
    output logic                        m_busy_res
);

    logic                        pend_valid_reg, pend_valid_next;
    aobf_pkg::pend_t             pend_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [aobf_pkg::BYTE_W-1:0] out_byte_reg;
    aobf_pkg::status_t           out_status_reg;
    logic [aobf_pkg::FILL_W-1:0] out_fill_reg;
    logic                        out_busy_reg;
    logic                        pend_move;

    assign pend_move = pend_valid_reg && (!out_valid_reg || m_ready);
    // the ram keeps its read data while the pending result is stuck, so hold off new transactions
    assign s_ready   = !pend_valid_reg || pend_move;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        if (accept) begin
            pend_valid_next = 1'b1;
        end else if (pend_move) begin
            pend_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (pend_move) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg <= res;
        end
        if (pend_move) begin
            out_byte_reg   <= pend_reg.rd_ok ? mem_rdata : '0;
            out_status_reg <= pend_reg.status;
            out_fill_reg   <= pend_reg.fill;
            out_busy_reg   <= pend_reg.busy;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_read_byte  = out_byte_reg;
    assign m_status     = out_status_reg;
    assign m_fill_level = out_fill_reg;
    assign m_busy_res   = out_busy_reg;

    a_stuck_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && !pend_move) |-> !s_ready)
        else $error("new transaction taken while read data is held");

    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_status_reg != aobf_pkg::ST_DONE)) |-> (out_byte_reg == '0))
        else $error("nonzero byte on a failed transaction");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !pend_move) |-> !pend_valid_reg)
        else $error("pending result overwritten");

endmodule

### rtl/core/audio_output_byte_fifo_top.sv
// top level of the audio output byte fifo
// A 16384-byte ring buffer that moves one byte per transaction: action 0 stores
// s_write_byte, action 1 returns the oldest byte. A write into a full buffer is
// dropped (status 1) or refused for retry (status 2, blocking mode); a read of an
// empty buffer returns zero with status 3. Each transaction gives exactly one
// result with the fill level after it and a busy flag that is set while free room
// is below the threshold register. A new transaction is taken every cycle as long
// as results are taken; the result of an accepted transaction waits in the pending
// register while the registered read of the single-port byte store, which also
// does the writes, completes, then moves into the output register once it is free.
// The store needs no clearing after reset. Config registers: index 0
// blocking mode (bit 0), index 1 busy room threshold (15 bits, reset 10240); write
// them only while the block is idle.
module audio_output_byte_fifo_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [aobf_pkg::BYTE_W-1:0]         s_write_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [aobf_pkg::BYTE_W-1:0]         m_read_byte,
    output logic [1:0]                          m_status,
    output logic [aobf_pkg::FILL_W-1:0]         m_fill_level,
    output logic                                m_busy_res,
    input  logic                                cfg_we,
    input  logic [aobf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aobf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic                        accept;
    aobf_pkg::mem_req_t          mem_req;
    aobf_pkg::pend_t             res;
    logic [aobf_pkg::BYTE_W-1:0] mem_rdata;

    assign accept = s_valid && s_ready;

    aobf_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .action     (s_action),
        .write_byte (s_write_byte),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mem_req    (mem_req),
        .res        (res)
    );

    aobf_ram #(
        .WIDTH (aobf_pkg::BYTE_W),
        .DEPTH (aobf_pkg::BUFFER_BYTES)
    ) u_store (
        .aclk  (aclk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

    aobf_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .res          (res),
        .mem_rdata    (mem_rdata),
        .s_ready      (s_ready),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_read_byte  (m_read_byte),
        .m_status     (m_status),
        .m_fill_level (m_fill_level),
        .m_busy_res   (m_busy_res)
    );

endmodule

### tb/sv/audio_output_byte_fifo_top_tb.sv
// self-checking testbench for the audio output byte fifo top level
module audio_output_byte_fifo_top_tb;
    import aobf_pkg::*;

    localparam int CYCLE_LIMIT = 12_000_000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 320;

    typedef struct {
        logic [BYTE_W-1:0] rbyte;
        status_t           status;
        logic [FILL_W-1:0] fill;
        logic              busy;
    } fifo_result_t;

    // tracks the ring contents and the results the block owes
    class ring_tracker;
        logic [BYTE_W-1:0] ring [BUFFER_BYTES];
        int                rd_ptr;
        int                wr_ptr;
        int                held;
        bit                blocking;
        int                room_limit;
        fifo_result_t      awaited[$];
        int                errors;

        function new();
            rd_ptr = 0;
            wr_ptr = 0;
            held = 0;
            blocking = 1'b0;
            room_limit = int'(THRESHOLD_RESET);
            errors = 0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("[%0t] error: %s", $time, what);
        endtask

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_BLOCKING)
                blocking = val[0];
            else if (idx == CFG_THRESHOLD)
                room_limit = int'(val[THR_W-1:0]);
        endfunction

        // applies one accepted transaction and queues its result
        function status_t note_item(action_t act, logic [BYTE_W-1:0] wbyte);
            fifo_result_t r;
            r.rbyte = '0;
            r.status = ST_DONE;
            if (act == ACT_WRITE) begin
                if (held >= BUFFER_BYTES) begin
                    r.status = blocking ? ST_REFUSED : ST_DROPPED;
                end else begin
                    ring[wr_ptr] = wbyte;
                    wr_ptr = (wr_ptr + 1) % BUFFER_BYTES;
                    held++;
                end
            end else begin
                if (held == 0) begin
                    r.status = ST_UNDERRUN;
                end else begin
                    r.rbyte = ring[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % BUFFER_BYTES;
                    held--;
                end
            end
            r.fill = FILL_W'(held);
            r.busy = ((BUFFER_BYTES - held) < room_limit);
            awaited.push_back(r);
            return r.status;
        endfunction

        task check_result(logic [BYTE_W-1:0] rbyte, logic [1:0] status,
                          logic [FILL_W-1:0] fill, logic busy);
            fifo_result_t e;
            if (awaited.size() == 0) begin
                report("result with no transaction pending");
            end else begin
                e = awaited.pop_front();
                if (rbyte !== e.rbyte)
                    report($sformatf("read_byte %0h, predicted %0h", rbyte, e.rbyte));
                if (status !== e.status)
                    report($sformatf("status %0d, predicted %0d", status, e.status));
                if (fill !== e.fill)
                    report($sformatf("fill_level %0d, predicted %0d", fill, e.fill));
                if (busy !== e.busy)
                    report($sformatf("busy %0b, predicted %0b", busy, e.busy));
            end
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_action;
    logic [BYTE_W-1:0]     s_write_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [BYTE_W-1:0]     m_read_byte;
    logic [1:0]            m_status;
    logic [FILL_W-1:0]     m_fill_level;
    logic                  m_busy_res;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    ring_tracker tracker = new();
    bit          calm;
    int          cycles;

    audio_output_byte_fifo_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_write_byte (s_write_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_byte  (m_read_byte),
        .m_status     (m_status),
        .m_fill_level (m_fill_level),
        .m_busy_res   (m_busy_res),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result(m_read_byte, m_status, m_fill_level, m_busy_res);
    end

    // mostly short gaps, now and then a long one, none while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure
    initial begin
        int run;
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            m_ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
            repeat (run) @(negedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_item(input action_t act, input logic [BYTE_W-1:0] wbyte,
                             output status_t st);
        int gap;
        s_valid <= 1'b1;
        s_action <= act;
        s_write_byte <= wbyte;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        st = tracker.note_item(act, wbyte);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(negedge aclk);
        cfg_we <= 1'b0;
        tracker.set_register(idx, CFG_DATA_W'(val));
        @(negedge aclk);
    endtask

    task automatic put(input action_t act, input logic [BYTE_W-1:0] wbyte);
        status_t st;
        send_item(act, wbyte, st);
    endtask

    initial begin
        int write_pct;
        int thr;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = ACT_WRITE;
        s_write_byte = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_BLOCKING;
        cfg_wdata = '0;
        calm = 1'b0;
        cycles = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty read, byte extremes, threshold extremes
        put(ACT_READ, 8'hFF);
        put(ACT_WRITE, 8'h00);
        put(ACT_WRITE, 8'hFF);
        put(ACT_WRITE, 8'h55);
        put(ACT_WRITE, 8'hAA);
        repeat (4) put(ACT_READ, 8'h00);
        put(ACT_READ, 8'h3C);
        wait_idle();
        write_cfg(CFG_THRESHOLD, BUFFER_BYTES);
        put(ACT_WRITE, 8'h0F);
        put(ACT_READ, 8'hF0);
        wait_idle();
        write_cfg(CFG_THRESHOLD, 0);
        put(ACT_WRITE, 8'h81);
        put(ACT_READ, 8'h7E);
        wait_idle();
        write_cfg(CFG_THRESHOLD, 32767);
        put(ACT_READ, 8'h00);
        put(ACT_WRITE, 8'h42);
        wait_idle();
        write_cfg(CFG_BLOCKING, 1);
        write_cfg(CFG_THRESHOLD, 1);
        put(ACT_WRITE, 8'h24);
        put(ACT_READ, 8'hFF);
        put(ACT_READ, 8'hFF);

        // random mixes with a threshold that is random, the buffer size or near the current free room
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            calm = ($urandom_range(0, 3) == 0);
            write_pct = $urandom_range(35, 70);
            case ($urandom_range(0, 3))
                0: thr = $urandom_range(0, 32767);
                1: thr = BUFFER_BYTES;
                default: begin
                    thr = BUFFER_BYTES - tracker.held + $urandom_range(0, 30) - 15;
                    if (thr < 0)
                        thr = 0;
                end
            endcase
            write_cfg(CFG_BLOCKING, $urandom_range(0, 1));
            write_cfg(CFG_THRESHOLD, thr);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < write_pct)
                    put(ACT_WRITE, BYTE_W'($urandom_range(0, 255)));
                else
                    put(ACT_READ, BYTE_W'($urandom_range(0, 255)));
            end
        end

        wait_idle();
        repeat (10) @(negedge aclk);
        if (tracker.awaited.size() != 0)
            tracker.report($sformatf("%0d results never arrived", tracker.awaited.size()));
        if (tracker.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
rtl/core/aobf_pkg.sv
rtl/core/aobf_ram.sv
rtl/core/aobf_ctrl.sv
rtl/core/aobf_out.sv
rtl/core/audio_output_byte_fifo_top.sv
tb/sv/audio_output_byte_fifo_top_tb.sv
